### design/gf2m_log_antilog_tables_core_assert.svh
// Assertion macros for the GF(2^m) log/antilog table core.
// Used by gf2m_log_antilog_tables_core; no other dependencies.
`ifndef GF2M_LOG_ANTILOG_TABLES_CORE_ASSERT_SVH
`define GF2M_LOG_ANTILOG_TABLES_CORE_ASSERT_SVH
`ifndef SYNTHESIS
`define GFLAT_ASSERT_RST(label, clk, rst, prop, msg) \
   label: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);
`define GFLAT_ASSERT_ANY(label, clk, prop, msg) \
   label: assert property (@(posedge clk) prop) else $error(msg);
`else
`define GFLAT_ASSERT_RST(label, clk, rst, prop, msg)
`define GFLAT_ASSERT_ANY(label, clk, prop, msg)
`endif
`endif

### design/gflat_pkg.sv
// Shared types and constants of the GF(2^m) log/antilog table core.
// No dependencies.
`default_nettype none
package gflat_pkg;

   localparam logic       ACT_BUILD     = 1'b0;
   localparam logic       ACT_LOOKUP    = 1'b1;

   localparam int unsigned CSR_IDX_W    = 1;
   localparam int unsigned CSR_DATA_W   = 9;
   localparam logic [CSR_IDX_W-1:0] CSR_FIELD_DEGREE = 1'b0;
   localparam logic [CSR_IDX_W-1:0] CSR_FIELD_POLY   = 1'b1;

   localparam logic [3:0] MIN_DEGREE    = 4'd2;
   localparam logic [3:0] DEGREE_RESET  = 4'd3;
   localparam logic [8:0] POLY_RESET    = 9'd11;

   typedef struct packed {
      logic       action;
      logic [7:0] exponent;
      logic [7:0] element;
   } req_word_type;

   typedef struct packed {
      logic [7:0] power_value;
      logic [7:0] log_value;
      logic       zero_element;
      logic       exponent_range_error;
      logic       not_primitive;
      logic       tables_ready;
   } rsp_word_type;

   typedef struct packed {
      logic       clear;
      logic       anti_we;
      logic [7:0] anti_addr;
      logic [7:0] anti_data;
      logic       log_we;
      logic [7:0] log_addr;
      logic [7:0] log_data;
   } store_wr_type;

   typedef struct packed {
      logic       en;
      logic [7:0] anti_addr;
      logic [7:0] log_addr;
   } store_rd_type;

   typedef struct packed {
      logic active;
      logic last;
      logic fault;
   } build_stat_type;

endpackage
`default_nettype wire

### design/gflat_store.sv
// Antilog and log memories with registered read and per-entry log valid bits.
// Depends on gflat_pkg.
`default_nettype none
module gflat_store #(
   parameter int unsigned AW = 8
) (
   input  logic                    clock,
   input  logic                    reset,
   input  gflat_pkg::store_wr_type wr,
   input  gflat_pkg::store_rd_type rd,
   output logic [7:0]              anti_rdata,
   output logic [7:0]              log_rdata,
   output logic                    log_rvalid
);
   import gflat_pkg::*;

   localparam int unsigned DEPTH = 1 << AW;

   logic [7:0]       anti_mem [DEPTH];
   logic [7:0]       log_mem  [DEPTH];
   logic [DEPTH-1:0] log_vld_ff;
   logic [7:0]       anti_rd_ff;
   logic [7:0]       log_rd_ff;
   logic             log_rvld_ff;

   always_ff @(posedge clock) begin
      if (wr.anti_we) begin
         anti_mem[wr.anti_addr[AW-1:0]] <= wr.anti_data;
      end
      if (wr.log_we) begin
         log_mem[wr.log_addr[AW-1:0]] <= wr.log_data;
      end
      if (rd.en) begin
         anti_rd_ff  <= anti_mem[rd.anti_addr[AW-1:0]];
         log_rd_ff   <= log_mem[rd.log_addr[AW-1:0]];
         log_rvld_ff <= log_vld_ff[rd.log_addr[AW-1:0]];
      end
   end

   // clear all log entries at once
   always_ff @(posedge clock) begin
      if (reset || wr.clear) begin
         log_vld_ff <= '0;
      end else if (wr.log_we) begin
         log_vld_ff[wr.log_addr[AW-1:0]] <= 1'b1;
      end
   end

   assign anti_rdata = anti_rd_ff;
   assign log_rdata  = log_rd_ff;
   assign log_rvalid = log_rvld_ff;

endmodule
`default_nettype wire

### design/gflat_build.sv
// Table build sequencer: walks the powers of alpha and issues store writes.
// Depends on gflat_pkg.
`default_nettype none
module gflat_build (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      go,
   input  logic [3:0]                degree,
   input  logic [8:0]                poly,
   output gflat_pkg::store_wr_type   wr,
   output gflat_pkg::build_stat_type stat
);
   import gflat_pkg::*;

   typedef enum logic {
      ST_IDLE,
      ST_WALK
   } state_type;

   state_type  state_ff;
   logic [7:0] e_ff;
   logic [7:0] p_ff;
   logic       fault_ff;

   logic [8:0] n_max;
   logic [8:0] shifted;
   logic [8:0] reduced;
   logic [7:0] p_in;
   logic       fault_cur;
   logic       walk;
   logic       at_last;

   assign n_max     = (9'd1 << degree) - 9'd1;
   assign shifted   = {p_ff, 1'b0};
   assign reduced   = (shifted[degree] ? (shifted ^ poly) : shifted) & n_max;
   assign p_in      = reduced[7:0];
   assign walk      = (state_ff == ST_WALK);
   assign fault_cur = fault_ff | ((e_ff != 8'd0) & (p_ff <= 8'd1));
   assign at_last   = ({1'b0, e_ff} == (n_max - 9'd1));

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         e_ff     <= 8'd0;
         p_ff     <= 8'd1;
         fault_ff <= 1'b0;
      end else begin
         unique case (state_ff)
            ST_IDLE: begin
               if (go) begin
                  state_ff <= ST_WALK;
                  e_ff     <= 8'd0;
                  p_ff     <= 8'd1;
                  fault_ff <= 1'b0;
               end
            end
            ST_WALK: begin
               e_ff     <= e_ff + 8'd1;
               p_ff     <= p_in;
               fault_ff <= fault_cur;
               if (at_last) begin
                  state_ff <= ST_IDLE;
               end
            end
            default: begin
               state_ff <= ST_IDLE;
            end
         endcase
      end
   end

   always_comb begin
      wr.clear     = go;
      wr.anti_we   = walk;
      wr.anti_addr = e_ff;
      wr.anti_data = p_ff;
      wr.log_we    = walk & ~fault_cur & (p_ff != 8'd0);
      wr.log_addr  = p_ff;
      wr.log_data  = e_ff;
      stat.active  = walk;
      stat.last    = walk & at_last;
      stat.fault   = fault_cur;
   end

endmodule
`default_nettype wire

### design/gf2m_log_antilog_tables_core.sv
// GF(2^m) log/antilog table core: lookups take one item per cycle while busy is low, with the
// result word in the cycle after the accepting edge; a build keeps busy high while it walks the
// powers of alpha, writing one antilog entry and at most one log entry per cycle, and its result
// word comes in the first cycle busy is low again. The log table is cleared at once when a build
// starts, so no clearing pass follows reset. Result words cannot be held off.
// Depends on gflat_pkg, gflat_build, gflat_store and the assertion macro header.
`default_nettype none
module gf2m_log_antilog_tables_core #(
   parameter int unsigned MAX_DEGREE = 8
) (
   input  logic                                   clock,
   input  logic                                   reset,
   input  logic                                   start,
   output logic                                   busy,
   input  gflat_pkg::req_word_type                req_word,
   output logic                                   rsp_valid,
   output gflat_pkg::rsp_word_type                rsp_word,
   input  logic                                   csr_valid,
   output logic                                   csr_ready,
   input  logic [gflat_pkg::CSR_IDX_W-1:0]        csr_index,
   input  logic [gflat_pkg::CSR_DATA_W-1:0]       csr_data
);
   import gflat_pkg::*;
   `include "gf2m_log_antilog_tables_core_assert.svh"

   localparam int unsigned DEPTH = 1 << MAX_DEGREE;

   logic [3:0]     deg_ff;
   logic [8:0]     poly_ff;
   logic           lk_vld_ff;
   logic           zero_ff;
   logic           rng_ff;
   logic           elhi_ff;
   logic           brsp_ff;
   logic           fault_ff;
   logic           built_ff;

   logic [3:0]     m_eff;
   logic [8:0]     n_top;
   logic           accept;
   logic           go;
   logic           lookup;
   store_wr_type   wr;
   store_rd_type   rd;
   build_stat_type stat;
   logic [7:0]     anti_rdata;
   logic [7:0]     log_rdata;
   logic           log_rvalid;

   always_comb begin
      priority if (deg_ff < MIN_DEGREE) begin
         m_eff = MIN_DEGREE;
      end else if (deg_ff > 4'(MAX_DEGREE)) begin
         m_eff = 4'(MAX_DEGREE);
      end else begin
         m_eff = deg_ff;
      end
   end

   assign n_top     = (9'd1 << m_eff) - 9'd1;
   assign busy      = stat.active;
   assign csr_ready = ~stat.active;
   assign accept    = start & ~busy;
   assign go        = accept & (req_word.action == ACT_BUILD);
   assign lookup    = accept & (req_word.action == ACT_LOOKUP);

   assign rd.en        = lookup;
   assign rd.anti_addr = req_word.exponent;
   assign rd.log_addr  = req_word.element;

   gflat_build u_build (
      .clock  (clock),
      .reset  (reset),
      .go     (go),
      .degree (m_eff),
      .poly   (poly_ff),
      .wr     (wr),
      .stat   (stat)
   );

   gflat_store #(
      .AW (MAX_DEGREE)
   ) u_store (
      .clock      (clock),
      .reset      (reset),
      .wr         (wr),
      .rd         (rd),
      .anti_rdata (anti_rdata),
      .log_rdata  (log_rdata),
      .log_rvalid (log_rvalid)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         deg_ff <= DEGREE_RESET;
         poly_ff <= POLY_RESET;
      end else if (csr_valid && csr_ready) begin
         unique case (csr_index)
            CSR_FIELD_DEGREE: deg_ff <= csr_data[3:0];
            CSR_FIELD_POLY:   poly_ff <= csr_data;
            default: begin
               deg_ff <= deg_ff;
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         lk_vld_ff <= 1'b0;
         brsp_ff   <= 1'b0;
         fault_ff  <= 1'b0;
         built_ff  <= 1'b0;
      end else begin
         lk_vld_ff <= lookup;
         brsp_ff   <= stat.last;
         if (stat.last) begin
            fault_ff <= stat.fault;
            built_ff <= 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (lookup) begin
         zero_ff <= (req_word.element == 8'd0);
         rng_ff  <= ({1'b0, req_word.exponent} >= n_top);
         elhi_ff <= ({1'b0, req_word.element} >= 9'(DEPTH));
      end
   end

   always_comb begin
      rsp_word.not_primitive = fault_ff;
      rsp_word.tables_ready  = built_ff;
      if (lk_vld_ff) begin
         rsp_word.zero_element         = zero_ff;
         rsp_word.exponent_range_error = rng_ff;
         rsp_word.power_value          = rng_ff ? 8'd0 : anti_rdata;
         rsp_word.log_value            = (zero_ff | elhi_ff | ~log_rvalid) ? 8'd0 : log_rdata;
      end else begin
         rsp_word.zero_element         = 1'b0;
         rsp_word.exponent_range_error = 1'b0;
         rsp_word.power_value          = 8'd0;
         rsp_word.log_value            = 8'd0;
      end
   end

   assign rsp_valid = lk_vld_ff | brsp_ff;

   `GFLAT_ASSERT_RST(a_one_word, clock, reset, !(lk_vld_ff && brsp_ff), "two result words at once")
   `GFLAT_ASSERT_RST(a_build_busy, clock, reset, go |=> busy, "build accepted without walk")
   `GFLAT_ASSERT_RST(a_build_ready, clock, reset, brsp_ff |-> built_ff, "build word without ready")
   `GFLAT_ASSERT_ANY(a_no_write_idle, clock, !busy |-> !wr.anti_we, "table write while idle")

endmodule
`default_nettype wire

### test/gf2m_table_checker.sv
// Checker for the GF(2^m) log/antilog table core: watches the request, result and CSR channels,
// predicts each result word from its own copy of the tables and field settings, and compares.
// Depends on gflat_pkg.
module gf2m_table_checker (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            start,
   input  logic                            busy,
   input  gflat_pkg::req_word_type         req_word,
   input  logic                            rsp_valid,
   input  gflat_pkg::rsp_word_type         rsp_word,
   input  logic                            csr_valid,
   input  logic                            csr_ready,
   input  logic [gflat_pkg::CSR_IDX_W-1:0] csr_index,
   input  logic [gflat_pkg::CSR_DATA_W-1:0] csr_data,
   output int                              errors,
   output int                              pending,
   output int                              checked
);
   import gflat_pkg::*;

   logic [7:0]   power_of_alpha [256];
   logic [7:0]   log_of_element [256];
   logic         tables_built;
   logic         early_return;
   logic [3:0]   field_degree;
   logic [8:0]   field_poly;
   rsp_word_type due_rsp_words [$];

   function automatic int unsigned group_order();
      int unsigned m;
      m = 32'(field_degree);
      if (m < 2) m = 2;
      if (m > 8) m = 8;
      return (1 << m) - 1;
   endfunction

   function automatic void rebuild_tables();
      int unsigned order;
      int unsigned e;
      logic [8:0]  p;
      logic        fault;
      order = group_order();
      p     = 9'd1;
      fault = 1'b0;
      foreach (log_of_element[i]) log_of_element[i] = 8'd0;
      for (e = 0; e < order; e++) begin
         if (e > 0 && (p == 9'd1 || p == 9'd0)) fault = 1'b1;
         power_of_alpha[e[7:0]] = p[7:0];
         if (!fault && p != 9'd0) log_of_element[p[7:0]] = e[7:0];
         p = p << 1;
         if (p[$clog2(order + 1)]) p = p ^ field_poly;
         p = p & order[8:0];
      end
      early_return = fault;
      tables_built = 1'b1;
   endfunction

   function automatic rsp_word_type predict_rsp(req_word_type w);
      rsp_word_type r;
      r = '0;
      if (w.action == ACT_BUILD) begin
         rebuild_tables();
      end else begin
         if (32'(w.exponent) >= group_order()) r.exponent_range_error = 1'b1;
         else r.power_value = power_of_alpha[w.exponent];
         if (w.element == 8'd0) r.zero_element = 1'b1;
         else r.log_value = log_of_element[w.element];
      end
      r.not_primitive = early_return;
      r.tables_ready  = tables_built;
      return r;
   endfunction

   function automatic int field_miss(string label, int unsigned want, int unsigned got);
      if (want == got) return 0;
      $display("%0t: %s expected %0d, got %0d", $time, label, want, got);
      return 1;
   endfunction

   always @(posedge clock) begin : watch
      rsp_word_type want;
      rsp_word_type next_word;
      if (reset) begin
         foreach (power_of_alpha[i]) power_of_alpha[i] = 8'd0;
         foreach (log_of_element[i]) log_of_element[i] = 8'd0;
         tables_built = 1'b0;
         early_return = 1'b0;
         field_degree = DEGREE_RESET;
         field_poly   = POLY_RESET;
         due_rsp_words.delete();
         errors  <= 0;
         checked <= 0;
         pending <= 0;
      end else begin
         if (rsp_valid) begin
            if (due_rsp_words.size() == 0) begin
               $display("%0t: result word expected none, got %p", $time, rsp_word);
               errors <= errors + 1;
            end else begin
               want = due_rsp_words.pop_front();
               errors <= errors
                  + field_miss("power_value", want.power_value, rsp_word.power_value)
                  + field_miss("log_value", want.log_value, rsp_word.log_value)
                  + field_miss("zero_element", want.zero_element, rsp_word.zero_element)
                  + field_miss("exponent_range_error", want.exponent_range_error,
                               rsp_word.exponent_range_error)
                  + field_miss("not_primitive", want.not_primitive, rsp_word.not_primitive)
                  + field_miss("tables_ready", want.tables_ready, rsp_word.tables_ready);
               checked <= checked + 1;
            end
         end
         if (csr_valid && csr_ready) begin
            if (csr_index == CSR_FIELD_DEGREE) field_degree = csr_data[3:0];
            else if (csr_index == CSR_FIELD_POLY) field_poly = csr_data;
         end
         if (start && !busy) begin
            next_word     = predict_rsp(req_word);
            due_rsp_words = {due_rsp_words, next_word};
         end
         pending <= due_rsp_words.size();
      end
   end

endmodule

### test/testbench.sv
// Top of the GF(2^m) log/antilog table core testbench: clock, reset, CSR settings and request
// stimulus, directed cases then random phases; the verdict comes from gf2m_table_checker.
// Depends on gflat_pkg, gf2m_log_antilog_tables_core and gf2m_table_checker.
module testbench;
   import gflat_pkg::*;

   localparam int unsigned CYCLE_LIMIT = 800_000;
   localparam int unsigned ITEM_TARGET = 620;

   logic                  clock = 1'b0;
   logic                  reset;
   logic                  start;
   logic                  busy;
   req_word_type          req_word;
   logic                  rsp_valid;
   rsp_word_type          rsp_word;
   logic                  csr_valid;
   logic                  csr_ready;
   logic [CSR_IDX_W-1:0]  csr_index;
   logic [CSR_DATA_W-1:0] csr_data;
   int                    errors;
   int                    pending;
   int                    checked;

   int                    cycles = 0;
   logic                  burst;
   logic [3:0]            cur_degree;
   int unsigned           written_span;
   int unsigned           n_lookups;
   int unsigned           n_builds;
   int unsigned           n_settings;

   gf2m_log_antilog_tables_core DUT (
      .clock     (clock),
      .reset     (reset),
      .start     (start),
      .busy      (busy),
      .req_word  (req_word),
      .rsp_valid (rsp_valid),
      .rsp_word  (rsp_word),
      .csr_valid (csr_valid),
      .csr_ready (csr_ready),
      .csr_index (csr_index),
      .csr_data  (csr_data)
   );

   gf2m_table_checker u_checker (
      .clock     (clock),
      .reset     (reset),
      .start     (start),
      .busy      (busy),
      .req_word  (req_word),
      .rsp_valid (rsp_valid),
      .rsp_word  (rsp_word),
      .csr_valid (csr_valid),
      .csr_ready (csr_ready),
      .csr_index (csr_index),
      .csr_data  (csr_data),
      .errors    (errors),
      .pending   (pending),
      .checked   (checked)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   always @(posedge clock) begin
      cycles <= cycles + 1;
      if (cycles == CYCLE_LIMIT) begin
         $display("tb: failure");
         $finish;
      end
   end

   function automatic int unsigned clamp_degree(logic [3:0] d);
      if (d < MIN_DEGREE) return 32'(MIN_DEGREE);
      if (d > 4'd8) return 8;
      return 32'(d);
   endfunction

   function automatic int unsigned field_span(logic [3:0] d);
      return (1 << clamp_degree(d)) - 1;
   endfunction

   function automatic logic [8:0] primitive_poly(int unsigned m);
      case (m)
         2: return 9'd7;
         3: return 9'd11;
         4: return 9'd19;
         5: return 9'd37;
         6: return 9'd67;
         7: return 9'd137;
         default: return 9'd285;
      endcase
   endfunction

   // keep in-range reads of the power table to entries some build has written
   function automatic logic [7:0] pick_exponent();
      int unsigned n;
      int unsigned readable;
      n        = field_span(cur_degree);
      readable = (written_span < n) ? written_span : n;
      if (readable > 0 && $urandom_range(0, 9) < 7) return 8'($urandom_range(0, readable - 1));
      return 8'($urandom_range(n, 255));
   endfunction

   function automatic logic [7:0] pick_element();
      if ($urandom_range(0, 3) != 0) return 8'($urandom_range(0, field_span(cur_degree)));
      return 8'($urandom_range(0, 255));
   endfunction

   task automatic send_word(input req_word_type w);
      int unsigned gap;
      req_word <= w;
      start    <= 1'b1;
      do @(posedge clock); while (busy);
      gap = burst ? 0 : $urandom_range(0, 17);
      if (gap > 0) begin
         start <= 1'b0;
         repeat (gap) @(posedge clock);
      end
   endtask

   task automatic request_lookup(input logic [7:0] e, input logic [7:0] v);
      req_word_type w;
      w.action   = ACT_LOOKUP;
      w.exponent = e;
      w.element  = v;
      n_lookups++;
      send_word(w);
   endtask

   task automatic request_build();
      req_word_type w;
      w.action   = ACT_BUILD;
      w.exponent = 8'($urandom_range(0, 255));
      w.element  = 8'($urandom_range(0, 255));
      n_builds++;
      if (field_span(cur_degree) > written_span) written_span = field_span(cur_degree);
      send_word(w);
   endtask

   task automatic set_field(input logic [3:0] deg, input logic [8:0] poly);
      logic [4:0] pad;
      pad = 5'($urandom_range(0, 31));
      start <= 1'b0;
      @(posedge clock);
      while (pending != 0) @(posedge clock);
      csr_valid <= 1'b1;
      csr_index <= CSR_FIELD_DEGREE;
      csr_data  <= {pad, deg};
      do @(posedge clock); while (!csr_ready);
      csr_index <= CSR_FIELD_POLY;
      csr_data  <= poly;
      do @(posedge clock); while (!csr_ready);
      csr_valid <= 1'b0;
      cur_degree = deg;
      n_settings++;
   endtask

   initial begin : stimulus
      logic [3:0]  deg;
      logic [8:0]  poly;
      int unsigned count;
      int unsigned choice;
      reset        = 1'b1;
      start        = 1'b0;
      req_word     = '0;
      csr_valid    = 1'b0;
      csr_index    = CSR_FIELD_DEGREE;
      csr_data     = '0;
      burst        = 1'b0;
      cur_degree   = DEGREE_RESET;
      written_span = 0;
      n_lookups    = 0;
      n_builds     = 0;
      n_settings   = 0;
      repeat (2) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      request_lookup(8'd255, 8'd0);
      request_lookup(8'd7, 8'd255);
      request_lookup(8'd200, 8'd5);
      request_build();
      request_lookup(8'd0, 8'd1);
      request_lookup(8'd6, 8'd7);
      request_lookup(8'd7, 8'd0);
      request_lookup(8'd255, 8'd255);
      set_field(4'd8, 9'd285);
      request_build();
      request_lookup(8'd254, 8'd255);
      request_lookup(8'd0, 8'd128);
      request_lookup(8'd255, 8'd0);
      set_field(4'd4, 9'd21);
      request_build();
      request_lookup(8'd14, 8'd15);
      request_lookup(8'd5, 8'd3);
      set_field(4'd0, 9'd0);
      request_build();
      request_lookup(8'd2, 8'd3);
      request_lookup(8'd3, 8'd2);
      set_field(4'd15, 9'd511);
      request_build();
      request_lookup(8'd100, 8'd200);
      set_field(4'd2, 9'd7);
      request_build();
      request_lookup(8'd1, 8'd2);

      while (n_lookups + n_builds < ITEM_TARGET) begin
         deg    = ($urandom_range(0, 9) < 7) ? 4'($urandom_range(2, 8))
                                             : 4'($urandom_range(0, 15));
         choice = $urandom_range(0, 3);
         if (choice < 2) poly = primitive_poly(clamp_degree(deg));
         else if (choice == 2)
            poly = 9'((32'd1 << clamp_degree(deg)) | $urandom_range(0, field_span(deg)));
         else poly = 9'($urandom_range(0, 511));
         set_field(deg, poly);
         burst = ($urandom_range(0, 3) == 0);
         if ($urandom_range(0, 6) != 0) request_build();
         count = $urandom_range(8, 40);
         repeat (count) begin
            if ($urandom_range(0, 24) == 0) request_build();
            else request_lookup(pick_exponent(), pick_element());
         end
      end

      start <= 1'b0;
      @(posedge clock);
      while (pending != 0) @(posedge clock);
      repeat (20) @(posedge clock);
      $display("run covered %0d lookups and %0d table builds over %0d field settings",
               n_lookups, n_builds, n_settings);
      $display("%0d result words compared, %0d field mismatches or stray words",
               checked, errors);
      if (errors == 0 && pending == 0) begin
         $display("tb: success");
      end else begin
         $display("tb: failure");
      end
      $finish;
   end

endmodule
